[hdl/sifs_pkg.sv]
// Package for the system information frame scheduler.
// Holds the configuration register map, the action codes and the configuration bundle type.
// Depends on nothing; every other file of the block uses it.
`timescale 1ns / 1ps

package sifs_pkg;

   // Number of entry words in the register map.
   localparam int CFG_ENTRIES = 3;

   // Register indexes of the configuration map (byte address is four times the index).
   typedef enum logic [2:0] {
      REG_BCAST_REP   = 3'd0,
      REG_CELL_ID     = 3'd1,
      REG_WINDOW      = 3'd2,
      REG_OFFSET      = 3'd3,
      REG_ENTRY_COUNT = 3'd4,
      REG_ENTRY_A     = 3'd5,
      REG_ENTRY_B     = 3'd6,
      REG_ENTRY_C     = 3'd7
   } reg_index_type;

   // Transaction kinds on the request channel.
   typedef enum logic {
      ACT_TICK    = 1'b0,
      ACT_CONSUME = 1'b1
   } action_type;

   // Broadcast repetition codes; any other code behaves as sixteen repetitions.
   localparam logic [1:0] BCAST_REP_4 = 2'd0;
   localparam logic [1:0] BCAST_REP_8 = 2'd1;

   // Register reset values.
   localparam logic [1:0]  RST_BCAST_REP   = 2'd0;
   localparam logic [8:0]  RST_CELL_ID     = 9'd1;
   localparam logic [7:0]  RST_WINDOW      = 8'd16;
   localparam logic [3:0]  RST_OFFSET      = 4'd0;
   localparam logic [1:0]  RST_ENTRY_COUNT = 2'd3;
   localparam logic [15:0] RST_ENTRY_A     = 16'd2070;
   localparam logic [15:0] RST_ENTRY_B     = 16'd2055;
   localparam logic [15:0] RST_ENTRY_C     = 16'd2088;

   // Configuration bundle passed from the register block to the scheduling core.
   typedef struct packed {
      logic [1:0]                   bcast_rep_code;
      logic [8:0]                   cell_id;
      logic [7:0]                   window_frames;
      logic [3:0]                   frame_offset;
      logic [1:0]                   entry_count;
      logic [CFG_ENTRIES-1:0][15:0] entry_word;
   } cfg_type;

endpackage

[hdl/sifs_csr.sv]
// Configuration register block of the system information frame scheduler.
// APB-style write and read access; depends on sifs_pkg for the register map and cfg_type.
`timescale 1ns / 1ps

module sifs_csr (
   input  logic               clock,
   input  logic               reset,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [4:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output sifs_pkg::cfg_type  cfg
);

   sifs_pkg::cfg_type     cfg_ff;
   sifs_pkg::reg_index_type reg_index;
   logic                  write_en;

   assign reg_index = sifs_pkg::reg_index_type'(paddr[4:2]);
   assign write_en  = psel && penable && pwrite;

   // Register writes complete in the access phase.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bcast_rep_code <= sifs_pkg::RST_BCAST_REP;
         cfg_ff.cell_id        <= sifs_pkg::RST_CELL_ID;
         cfg_ff.window_frames  <= sifs_pkg::RST_WINDOW;
         cfg_ff.frame_offset   <= sifs_pkg::RST_OFFSET;
         cfg_ff.entry_count    <= sifs_pkg::RST_ENTRY_COUNT;
         cfg_ff.entry_word[0]  <= sifs_pkg::RST_ENTRY_A;
         cfg_ff.entry_word[1]  <= sifs_pkg::RST_ENTRY_B;
         cfg_ff.entry_word[2]  <= sifs_pkg::RST_ENTRY_C;
      end else if (write_en) begin
         case (reg_index)
            sifs_pkg::REG_BCAST_REP:   cfg_ff.bcast_rep_code <= pwdata[1:0];
            sifs_pkg::REG_CELL_ID:     cfg_ff.cell_id        <= pwdata[8:0];
            sifs_pkg::REG_WINDOW:      cfg_ff.window_frames  <= pwdata[7:0];
            sifs_pkg::REG_OFFSET:      cfg_ff.frame_offset   <= pwdata[3:0];
            sifs_pkg::REG_ENTRY_COUNT: cfg_ff.entry_count    <= pwdata[1:0];
            sifs_pkg::REG_ENTRY_A:     cfg_ff.entry_word[0]  <= pwdata[15:0];
            sifs_pkg::REG_ENTRY_B:     cfg_ff.entry_word[1]  <= pwdata[15:0];
            sifs_pkg::REG_ENTRY_C:     cfg_ff.entry_word[2]  <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   // Read data, zero extended to the bus width.
   always_comb begin
      case (reg_index)
         sifs_pkg::REG_BCAST_REP:   prdata = {30'd0, cfg_ff.bcast_rep_code};
         sifs_pkg::REG_CELL_ID:     prdata = {23'd0, cfg_ff.cell_id};
         sifs_pkg::REG_WINDOW:      prdata = {24'd0, cfg_ff.window_frames};
         sifs_pkg::REG_OFFSET:      prdata = {28'd0, cfg_ff.frame_offset};
         sifs_pkg::REG_ENTRY_COUNT: prdata = {30'd0, cfg_ff.entry_count};
         sifs_pkg::REG_ENTRY_A:     prdata = {16'd0, cfg_ff.entry_word[0]};
         sifs_pkg::REG_ENTRY_B:     prdata = {16'd0, cfg_ff.entry_word[1]};
         sifs_pkg::REG_ENTRY_C:     prdata = {16'd0, cfg_ff.entry_word[2]};
         default:                   prdata = 32'd0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

[hdl/sifs_core.sv]
// Scheduling core: broadcast frame check, window reloads, first-due entry search and
// consume handling, plus the per-entry repetition and subframe counters. Uses sifs_pkg.
`timescale 1ns / 1ps

module sifs_core #(
   parameter int NUM_ENTRIES = 3
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              update_en,
   input  sifs_pkg::cfg_type cfg,
   input  logic              action,
   input  logic [19:0]       frame_number,
   input  logic [1:0]        entry_select,
   output logic              res_bcast_frame,
   output logic [1:0]        res_entry_due,
   output logic [7:0]        res_subframes_left
);

   localparam logic [1:0] NUM_W = 2'(NUM_ENTRIES);

   logic [7:0] reps_left_ff [NUM_ENTRIES];
   logic [7:0] reps_left_in [NUM_ENTRIES];
   logic [7:0] subf_left_ff [NUM_ENTRIES];
   logic [7:0] subf_left_in [NUM_ENTRIES];

   logic [7:0] reps_eff  [NUM_ENTRIES];
   logic [7:0] subf_eff  [NUM_ENTRIES];
   logic       phase_ok  [NUM_ENTRIES];

   logic [1:0] active_count;
   logic [5:0] bc_mask;
   logic [5:0] bc_start;
   logic [6:0] bc_diff;
   logic       bc_hit;

   // Broadcast block: phase within its span, offset by the cell-dependent start frame.
   always_comb begin
      case (cfg.bcast_rep_code)
         sifs_pkg::BCAST_REP_4: begin
            bc_mask  = 6'd63;
            bc_start = {cfg.cell_id[1:0], 4'd0};
         end
         sifs_pkg::BCAST_REP_8: begin
            bc_mask  = 6'd31;
            bc_start = {1'b0, cfg.cell_id[0], 4'd0};
         end
         default: begin
            bc_mask  = 6'd15;
            bc_start = {5'd0, cfg.cell_id[0]};
         end
      endcase
   end

   assign bc_diff = {1'b0, frame_number[5:0] & bc_mask} - {1'b0, bc_start};
   assign bc_hit  = !bc_diff[6] && !bc_diff[0] && (bc_diff[5:4] == 2'd0);

   assign active_count = (cfg.entry_count > NUM_W) ? NUM_W : cfg.entry_count;

   // Per-entry window start detection and reload values, all entries side by side.
   for (genvar gi = 0; gi < NUM_ENTRIES; gi++) begin : g_entry
      logic [15:0] word;
      logic [14:0] period_mask;
      logic [14:0] phase;
      logic [14:0] win_start;
      logic [2:0]  rep_log;
      logic [3:0]  rep_mask;
      logic        win_open;

      assign word        = cfg.entry_word[gi];
      assign period_mask = 15'((16'd1 << word[3:0]) - 16'd1);
      assign phase       = frame_number[14:0] & period_mask;
      assign win_start   = 15'(gi) * {7'd0, cfg.window_frames} + {11'd0, cfg.frame_offset};
      assign win_open    = (phase == win_start);
      assign rep_log     = {1'b0, word[5:4]} + 3'd1;
      assign rep_mask    = 4'((5'd1 << rep_log) - 5'd1);

      assign reps_eff[gi] = win_open ? (cfg.window_frames >> rep_log) : reps_left_ff[gi];
      assign subf_eff[gi] = win_open ? word[15:8] : subf_left_ff[gi];
      assign phase_ok[gi] = ((phase[3:0] & rep_mask) == 4'd0);
   end

   // Tick entry walk in priority order; the first due entry stops the walk.
   always_comb begin
      logic found;
      found              = 1'b0;
      reps_left_in       = reps_left_ff;
      subf_left_in       = subf_left_ff;
      res_bcast_frame    = 1'b0;
      res_entry_due      = 2'd0;
      res_subframes_left = 8'd0;
      if (action == sifs_pkg::ACT_CONSUME) begin
         for (int i = 0; i < NUM_ENTRIES; i++) begin
            if (entry_select == 2'(i + 1)) begin
               subf_left_in[i]    = (subf_left_ff[i] != 8'd0) ? subf_left_ff[i] - 8'd1 : 8'd0;
               res_entry_due      = entry_select;
               res_subframes_left = subf_left_in[i];
            end
         end
      end else begin
         res_bcast_frame = bc_hit;
         for (int i = 0; i < NUM_ENTRIES; i++) begin
            if (!found && (2'(i) < active_count)) begin
               reps_left_in[i] = reps_eff[i];
               subf_left_in[i] = subf_eff[i];
               if ((reps_eff[i] != 8'd0) && phase_ok[i]) begin
                  reps_left_in[i]    = reps_eff[i] - 8'd1;
                  res_entry_due      = 2'(i + 1);
                  res_subframes_left = subf_eff[i];
                  found              = 1'b1;
               end
            end
         end
      end
   end

   // Counter state, updated once per transaction as it leaves the input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_ENTRIES; i++) begin
            reps_left_ff[i] <= 8'd0;
            subf_left_ff[i] <= 8'd0;
         end
      end else if (update_en) begin
         reps_left_ff <= reps_left_in;
         subf_left_ff <= subf_left_in;
      end
   end

endmodule

[hdl/system_info_frame_scheduler.sv]
// System information frame scheduler, top level.
// An accepted transaction passes through the input register and then the result register.
// One transaction per cycle if no result is held; counters are read and updated in one pass.
// Reset clears the counters and both valid flags and returns registers to their defaults.
// Depends on sifs_pkg, sifs_csr and sifs_core.
`timescale 1ns / 1ps

module system_info_frame_scheduler #(
   parameter int NUM_ENTRIES = 3
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_action,
   input  logic [19:0] req_frame_number,
   input  logic [1:0]  req_entry_select,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_bcast_frame,
   output logic [1:0]  rsp_entry_due,
   output logic [7:0]  rsp_subframes_left,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam logic [1:0] NUM_W = 2'(NUM_ENTRIES);

   sifs_pkg::cfg_type cfg;

   logic        in_valid_ff;
   logic        in_valid_in;
   logic        in_action_ff;
   logic [19:0] in_frame_ff;
   logic [1:0]  in_select_ff;

   logic        out_valid_ff;
   logic        out_valid_in;
   logic        out_bcast_ff;
   logic [1:0]  out_due_ff;
   logic [7:0]  out_left_ff;

   logic        res_bcast_frame;
   logic [1:0]  res_entry_due;
   logic [7:0]  res_subframes_left;

   logic        advance;
   logic        req_take;

   assign pready = 1'b1;

   sifs_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .cfg     (cfg)
   );

   sifs_core #(
      .NUM_ENTRIES (NUM_ENTRIES)
   ) u_core (
      .clock              (clock),
      .reset              (reset),
      .update_en          (advance && in_valid_ff),
      .cfg                (cfg),
      .action             (in_action_ff),
      .frame_number       (in_frame_ff),
      .entry_select       (in_select_ff),
      .res_bcast_frame    (res_bcast_frame),
      .res_entry_due      (res_entry_due),
      .res_subframes_left (res_subframes_left)
   );

   // Handshake: the input register moves on whenever the result register is free or drained.
   assign advance      = !out_valid_ff || !rsp_stall;
   assign req_stall    = in_valid_ff && !advance;
   assign req_take     = req_valid && !req_stall;
   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance ? in_valid_ff : out_valid_ff;

   // Valid flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Input register payload.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_action_ff <= req_action;
         in_frame_ff  <= req_frame_number;
         in_select_ff <= req_entry_select;
      end
   end

   // Result register payload.
   always_ff @(posedge clock) begin
      if (advance && in_valid_ff) begin
         out_bcast_ff <= res_bcast_frame;
         out_due_ff   <= res_entry_due;
         out_left_ff  <= res_subframes_left;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_bcast_frame    = out_bcast_ff;
   assign rsp_entry_due      = out_due_ff;
   assign rsp_subframes_left = out_left_ff;

   // A result that names no entry carries no subframe count.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_entry_due == 2'd0)) |-> (rsp_subframes_left == 8'd0))
      else $error("subframe count reported without an entry");

   // Only entries within the entry table are ever reported.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_entry_due <= NUM_W))
      else $error("reported entry beyond the entry table");

   // The request side stalls only when both registers are full and the result is held.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && out_valid_ff && rsp_stall))
      else $error("request stalled with room in the pipeline");

   // A held result keeps the transaction waiting in the input register.
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && out_valid_ff && rsp_stall) |=> in_valid_ff)
      else $error("transaction lost from the input register");

endmodule
